>>> design/bsd_pkg.sv
package bsd_pkg;

    localparam int SymbolWidth = 8;
    localparam int ByteWidth = 8;
    localparam int SextetWidth = 6;
    localparam int CountWidth = 16;
    localparam int GroupTotalWidth = 17;
    localparam int CodeWidth = 2;

    localparam logic [SymbolWidth-1:0] PadChar = 8'h3D;
    localparam logic [CountWidth-1:0] CapacityReset = 16'd2047;
    localparam logic [CountWidth-1:0] CountMax = 16'hFFFF;
    localparam logic [GroupTotalWidth-1:0] GroupTotalMax = 17'h1FFFF;
    localparam logic [GroupTotalWidth-1:0] GroupBytes = 17'd3;

    localparam logic [CodeWidth-1:0] StatusOk = 2'd0;
    localparam logic [CodeWidth-1:0] StatusBadLength = 2'd1;
    localparam logic [CodeWidth-1:0] StatusBadChar = 2'd2;
    localparam logic [CodeWidth-1:0] StatusOverCapacity = 2'd3;

    typedef struct packed {
        logic ok;
        logic [SextetWidth-1:0] value;
    } sextet_t;

    function automatic sextet_t sextet_of(input logic [SymbolWidth-1:0] ch);
        sextet_t s;
        s.ok = 1'b1;
        s.value = '0;
        if (ch >= 8'h41 && ch <= 8'h5A)
        begin
            s.value = 6'(ch - 8'h41);
        end
        else if (ch >= 8'h61 && ch <= 8'h7A)
        begin
            s.value = 6'(ch - 8'h61 + 8'd26);
        end
        else if (ch >= 8'h30 && ch <= 8'h39)
        begin
            s.value = 6'(ch - 8'h30 + 8'd52);
        end
        else if (ch == 8'h2B)
        begin
            s.value = 6'd62;
        end
        else if (ch == 8'h2F)
        begin
            s.value = 6'd63;
        end
        else if (ch == PadChar)
        begin
            s.value = '0;
        end
        else
        begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

endpackage

>>> design/base64_stream_decoder.sv
// Base64 stream decoder.
// The input channel (in_valid, in_stall, symbol, final_symbol) takes one
// character per word; final_symbol marks the last character of a string.
// The output channel (out_valid, out_stall and the result fields) gives one
// result word per cycle while not stalled: data bytes, and after the final
// character a status word with the code and the string's decoded byte count.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes the
// capacity register; cfg_ready is always high.
// Decoding and the per-string state update happen in the cycle a character is
// accepted, and its first result word is offered in the next cycle.
// A character is accepted in every cycle as long as each one yields at most
// one result word and out_stall stays low. A character that yields more
// words holds in_stall high while the result register drains them one a cycle.
// When the receiver stalls, the result register holds its words and in_stall
// stays high while any word waits, dropping only in the cycle the last of them
// is taken; no word is lost.
// Reset clears all string state and pending results and sets the capacity
// to 2047 bytes.
module base64_stream_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bsd_pkg::SymbolWidth-1:0] symbol,
    input  logic                          final_symbol,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bsd_pkg::ByteWidth-1:0] out_byte,
    output logic                          is_status,
    output logic [bsd_pkg::CodeWidth-1:0] status_code,
    output logic [bsd_pkg::CountWidth-1:0] decoded_count,
    output logic                          last_of_run,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bsd_pkg::CountWidth-1:0] cfg_data
);
    import bsd_pkg::*;

    logic [CountWidth-1:0] capacity_reg;
    logic [3*SextetWidth-1:0] held_reg, held_next;
    logic third_pad_reg, third_pad_next;
    logic [1:0] pos_reg, pos_next;
    logic bad_reg, bad_next;
    logic over_reg, over_next;
    logic [GroupTotalWidth-1:0] total_reg, total_next;
    logic [CountWidth-1:0] count_reg, count_next;

    logic [3:0] pend_reg, pend_next, pend_load;
    logic [ByteWidth-1:0] byte_reg [3];
    logic [CodeWidth-1:0] code_reg, code_load;
    logic [CountWidth-1:0] status_count_reg;

    logic in_take, out_take, pend_single;
    sextet_t sx;
    logic [4*SextetWidth-1:0] triple;
    logic [1:0] n_bytes;
    logic [GroupTotalWidth-1:0] count_sum;

    assign cfg_ready = 1'b1;
    assign pend_single = ((pend_reg & (pend_reg - 4'd1)) == 4'd0);
    assign out_valid = |pend_reg;
    assign out_take = out_valid && !out_stall;
    assign in_stall = out_valid && !(out_take && pend_single);
    assign in_take = in_valid && !in_stall;
    assign last_of_run = pend_single;

    always_comb
    begin
        out_byte = '0;
        is_status = 1'b0;
        status_code = StatusOk;
        decoded_count = '0;
        priority if (pend_reg[0])
        begin
            out_byte = byte_reg[0];
        end
        else if (pend_reg[1])
        begin
            out_byte = byte_reg[1];
        end
        else if (pend_reg[2])
        begin
            out_byte = byte_reg[2];
        end
        else
        begin
            is_status = pend_reg[3];
            status_code = code_reg;
            decoded_count = status_count_reg;
        end
    end

    always_comb
    begin
        sx = sextet_of(symbol);
        triple = {held_reg, sx.value};
        held_next = held_reg;
        third_pad_next = third_pad_reg;
        pos_next = pos_reg;
        bad_next = bad_reg;
        over_next = over_reg;
        total_next = total_reg;
        count_next = count_reg;
        pend_load = 4'b0000;
        n_bytes = 2'd0;
        count_sum = '0;
        code_load = StatusOk;
        if (pos_reg != 2'd3)
        begin
            if (!sx.ok && pos_reg != 2'd2)
            begin
                bad_next = 1'b1;
            end
            if (pos_reg == 2'd2)
            begin
                third_pad_next = (symbol == PadChar);
            end
            held_next = {held_reg[2*SextetWidth-1:0], sx.value};
            pos_next = 2'(pos_reg + 2'd1);
        end
        else
        begin
            pos_next = 2'd0;
            if (total_reg > GroupTotalMax - GroupBytes)
            begin
                total_next = GroupTotalMax;
            end
            else
            begin
                total_next = total_reg + GroupBytes;
            end
            if (total_next > {1'b0, capacity_reg})
            begin
                over_next = 1'b1;
            end
            if (!bad_reg)
            begin
                pend_load[0] = 1'b1;
                pend_load[1] = !third_pad_reg;
                pend_load[2] = (symbol != PadChar);
                n_bytes = 2'(2'd1 + {1'b0, pend_load[1]} + {1'b0, pend_load[2]});
                count_sum = {1'b0, count_reg} + {15'd0, n_bytes};
                if (count_sum > {1'b0, CountMax})
                begin
                    count_next = CountMax;
                end
                else
                begin
                    count_next = count_sum[CountWidth-1:0];
                end
            end
            held_next = '0;
            third_pad_next = 1'b0;
        end
        if (final_symbol)
        begin
            pend_load[3] = 1'b1;
            priority if (pos_next != 2'd0)
            begin
                code_load = StatusBadLength;
            end
            else if (over_next)
            begin
                code_load = StatusOverCapacity;
            end
            else if (bad_next)
            begin
                code_load = StatusBadChar;
            end
            else
            begin
                code_load = StatusOk;
            end
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (out_take)
        begin
            pend_next = pend_reg & (pend_reg - 4'd1);
        end
        if (in_take)
        begin
            pend_next = pend_load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CapacityReset;
            held_reg <= '0;
            third_pad_reg <= 1'b0;
            pos_reg <= 2'd0;
            bad_reg <= 1'b0;
            over_reg <= 1'b0;
            total_reg <= '0;
            count_reg <= '0;
            pend_reg <= 4'b0000;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
            pend_reg <= pend_next;
            if (in_take)
            begin
                if (final_symbol)
                begin
                    held_reg <= '0;
                    third_pad_reg <= 1'b0;
                    pos_reg <= 2'd0;
                    bad_reg <= 1'b0;
                    over_reg <= 1'b0;
                    total_reg <= '0;
                    count_reg <= '0;
                end
                else
                begin
                    held_reg <= held_next;
                    third_pad_reg <= third_pad_next;
                    pos_reg <= pos_next;
                    bad_reg <= bad_next;
                    over_reg <= over_next;
                    total_reg <= total_next;
                    count_reg <= count_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg[0] <= triple[3*ByteWidth-1:2*ByteWidth];
            byte_reg[1] <= triple[2*ByteWidth-1:ByteWidth];
            byte_reg[2] <= triple[ByteWidth-1:0];
            code_reg <= code_load;
            status_count_reg <= count_next;
        end
    end

endmodule

>>> bench/base64_decode_checker.sv
`timescale 1ns / 1ps

module base64_decode_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [bsd_pkg::SymbolWidth-1:0] symbol,
    input  logic                            final_symbol,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [bsd_pkg::ByteWidth-1:0]   out_byte,
    input  logic                            is_status,
    input  logic [bsd_pkg::CodeWidth-1:0]   status_code,
    input  logic [bsd_pkg::CountWidth-1:0]  decoded_count,
    input  logic                            last_of_run,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [bsd_pkg::CountWidth-1:0]  cfg_data,
    output int                              mismatch_count,
    output int                              pending_words,
    output int                              data_words,
    output int                              status_words
);

    typedef struct packed {
        logic [bsd_pkg::ByteWidth-1:0]  data;
        logic                           status;
        logic [bsd_pkg::CodeWidth-1:0]  code;
        logic [bsd_pkg::CountWidth-1:0] count;
        logic                           last;
    } decode_word_t;

    decode_word_t expected_words[$];

    logic [bsd_pkg::CountWidth-1:0]      capacity;
    logic [17:0]                         held;
    logic                                third_pad;
    logic [1:0]                          grp_pos;
    logic                                bad_seen;
    logic                                over_seen;
    logic [bsd_pkg::GroupTotalWidth-1:0] group_total;
    logic [bsd_pkg::CountWidth-1:0]      byte_count;
    int                                  errors;
    int                                  data_seen;
    int                                  status_seen;

    function automatic bit decode_char(input logic [7:0] ch, output logic [5:0] value);
        value = '0;
        if (ch >= 8'h41 && ch <= 8'h5A)
        begin
            value = 6'(ch - 8'h41);
            return 1'b1;
        end
        if (ch >= 8'h61 && ch <= 8'h7A)
        begin
            value = 6'(ch - 8'h61 + 8'd26);
            return 1'b1;
        end
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            value = 6'(ch - 8'h30 + 8'd52);
            return 1'b1;
        end
        if (ch == 8'h2B)
        begin
            value = 6'd62;
            return 1'b1;
        end
        if (ch == 8'h2F)
        begin
            value = 6'd63;
            return 1'b1;
        end
        return (ch == bsd_pkg::PadChar);
    endfunction

    function automatic void clear_string();
        held = '0;
        third_pad = 1'b0;
        grp_pos = 2'd0;
        bad_seen = 1'b0;
        over_seen = 1'b0;
        group_total = '0;
        byte_count = '0;
    endfunction

    function automatic void push_word(input logic [7:0] data, input logic status,
                                      input logic [1:0] code, input logic [15:0] count);
        decode_word_t w;
        w.data = data;
        w.status = status;
        w.code = code;
        w.count = count;
        w.last = 1'b0;
        expected_words.push_back(w);
    endfunction

    task automatic decode_symbol(input logic [7:0] ch, input logic fin);
        logic [5:0]  sx;
        logic        ok;
        logic [23:0] group;
        logic [16:0] sum;
        logic [1:0]  code;
        int          first_new;
        int          emitted;
        decode_word_t w;
        first_new = expected_words.size();
        ok = decode_char(ch, sx);
        if (grp_pos != 2'd3)
        begin
            if (!ok && grp_pos < 2'd2)
                bad_seen = 1'b1;
            if (grp_pos == 2'd2)
                third_pad = (ch == bsd_pkg::PadChar);
            held = {held[11:0], sx};
            grp_pos = grp_pos + 2'd1;
        end
        else
        begin
            group = {held, sx};
            grp_pos = 2'd0;
            if (group_total > bsd_pkg::GroupTotalMax - bsd_pkg::GroupBytes)
                group_total = bsd_pkg::GroupTotalMax;
            else
                group_total = group_total + bsd_pkg::GroupBytes;
            if (group_total > {1'b0, capacity})
                over_seen = 1'b1;
            if (!bad_seen)
            begin
                emitted = 1;
                push_word(group[23:16], 1'b0, bsd_pkg::StatusOk, '0);
                if (!third_pad)
                begin
                    push_word(group[15:8], 1'b0, bsd_pkg::StatusOk, '0);
                    emitted++;
                end
                if (ch != bsd_pkg::PadChar)
                begin
                    push_word(group[7:0], 1'b0, bsd_pkg::StatusOk, '0);
                    emitted++;
                end
                sum = {1'b0, byte_count} + 17'(emitted);
                byte_count = (sum > {1'b0, bsd_pkg::CountMax}) ? bsd_pkg::CountMax : sum[15:0];
            end
            held = '0;
            third_pad = 1'b0;
        end
        if (fin)
        begin
            if (grp_pos != 2'd0)
                code = bsd_pkg::StatusBadLength;
            else if (over_seen)
                code = bsd_pkg::StatusOverCapacity;
            else if (bad_seen)
                code = bsd_pkg::StatusBadChar;
            else
                code = bsd_pkg::StatusOk;
            push_word('0, 1'b1, code, byte_count);
            clear_string();
        end
        if (expected_words.size() > first_new)
        begin
            w = expected_words.pop_back();
            w.last = 1'b1;
            expected_words.push_back(w);
        end
    endtask

    task automatic check_word();
        decode_word_t seen;
        decode_word_t want;
        seen = {out_byte, is_status, status_code, decoded_count, last_of_run};
        if (expected_words.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("%0t: unexpected word: byte %h status %b code %0d count %0d last %b",
                         $realtime, seen.data, seen.status, seen.code, seen.count, seen.last);
        end
        else
        begin
            want = expected_words.pop_front();
            if (seen !== want)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("%0t: word mismatch", $realtime);
                    $display("  expected byte %h status %b code %0d count %0d last %b",
                             want.data, want.status, want.code, want.count, want.last);
                    $display("  actual   byte %h status %b code %0d count %0d last %b",
                             seen.data, seen.status, seen.code, seen.count, seen.last);
                end
            end
            if (want.status)
                status_seen++;
            else
                data_seen++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity = bsd_pkg::CapacityReset;
            clear_string();
            expected_words.delete();
            errors = 0;
            data_seen = 0;
            status_seen = 0;
            mismatch_count <= 0;
            pending_words <= 0;
            data_words <= 0;
            status_words <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                decode_symbol(symbol, final_symbol);
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;
            if (out_valid && !out_stall)
                check_word();
            mismatch_count <= errors;
            pending_words <= expected_words.size();
            data_words <= data_seen;
            status_words <= status_seen;
        end
    end

endmodule

>>> bench/tb_base64_stream_decoder.sv
`timescale 1ns / 1ps

module tb_base64_stream_decoder;

    localparam int IdleLimit = 2000;
    localparam int DrainCycles = 8;
    localparam int PhaseItems = 50;
    localparam int PhaseCount = 5;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [bsd_pkg::SymbolWidth-1:0] symbol = '0;
    logic                            final_symbol = 1'b0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [bsd_pkg::ByteWidth-1:0]   out_byte;
    logic                            is_status;
    logic [bsd_pkg::CodeWidth-1:0]   status_code;
    logic [bsd_pkg::CountWidth-1:0]  decoded_count;
    logic                            last_of_run;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [bsd_pkg::CountWidth-1:0]  cfg_data = '0;

    int mismatch_count;
    int pending_words;
    int data_words;
    int status_words;

    int idle_cycles = 0;
    int burst_left = 0;
    int stall_left = 0;
    int stall_mode = 1;
    bit sender_gaps = 1'b1;
    bit stall_now = 1'b0;
    int items_sent = 0;
    int strings_sent = 0;

    logic [7:0] text[$];

    base64_stream_decoder dut (.*);

    base64_decode_checker checker_inst (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else
        begin
            case (stall_mode)
                0:
                begin
                    stall_now = 1'b0;
                end
                1:
                begin
                    stall_now = ($urandom_range(0, 3) == 0);
                end
                default:
                begin
                    stall_now = $urandom_range(0, 1);
                    stall_left = $urandom_range(0, 6);
                end
            endcase
        end
        out_stall <= stall_now;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= IdleLimit);
        $display("tb_base64_stream_decoder: errors");
        $finish;
    end

    function automatic logic [7:0] alphabet_char(input int idx);
        if (idx < 26)
            return 8'(8'h41 + idx);
        if (idx < 52)
            return 8'(8'h61 + idx - 26);
        if (idx < 62)
            return 8'(8'h30 + idx - 52);
        if (idx == 62)
            return 8'h2B;
        return 8'h2F;
    endfunction

    task automatic send_symbol(input logic [7:0] ch, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            gap = 0;
            if (sender_gaps)
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_valid <= 1'b1;
        symbol <= ch;
        final_symbol <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text.size(); i++)
            send_symbol(text[i], i == text.size() - 1);
        strings_sent++;
    endtask

    task automatic load_text(input string s);
        text.delete();
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
    endtask

    task automatic build_random_string();
        int len;
        int roll;
        text.delete();
        if ($urandom_range(0, 9) < 7)
            len = 4 * $urandom_range(1, 5);
        else
            len = $urandom_range(1, 13);
        for (int i = 0; i < len; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 6)
                text.push_back(8'($urandom_range(0, 255)));
            else if (roll < 9)
                text.push_back(bsd_pkg::PadChar);
            else
                text.push_back(alphabet_char($urandom_range(0, 63)));
        end
        if (len % 4 == 0 && $urandom_range(0, 2) == 0)
        begin
            text[len-1] = bsd_pkg::PadChar;
            if ($urandom_range(0, 1))
                text[len-2] = bsd_pkg::PadChar;
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int phase_start;
        logic [15:0] cap;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_text("AZaz09+/");
        send_text();
        load_text("QUxxQQ==");
        text[2] = 8'h00;
        text[3] = 8'hFF;
        send_text();
        load_text("QUI=");
        send_text();
        load_text("x=AA");
        text[0] = 8'hFF;
        send_text();
        load_text("AB");
        send_text();
        settle();

        for (int p = 0; p < PhaseCount; p++)
        begin
            case (p)
                0: cap = 16'd0;
                1: cap = 16'hFFFF;
                2: cap = 16'd6;
                3: cap = 16'($urandom_range(0, 48));
                default: cap = 16'($urandom_range(0, 65535));
            endcase
            write_capacity(cap);
            stall_mode = (p == 0) ? 0 : (p % 2 == 1) ? 2 : 1;
            sender_gaps = (p != 0);
            phase_start = items_sent;
            while (items_sent - phase_start < PhaseItems)
            begin
                build_random_string();
                send_text();
            end
            settle();
        end

        $display("Run covered %0d characters in %0d strings over %0d capacity settings.",
                 items_sent, strings_sent, PhaseCount + 1);
        $display("Checked %0d data bytes and %0d status words.", data_words, status_words);
        if (mismatch_count == 0 && pending_words == 0)
            $display("tb_base64_stream_decoder: clean");
        else
            $display("tb_base64_stream_decoder: errors");
        $finish;
    end

endmodule
